/* hdl/fifc_pkg.sv */
// ----------------------------------------------------------------------------
// fifc_pkg
// Shared types, codes and format constants for the float/integer converter.
// ----------------------------------------------------------------------------
package fifc_pkg;

    localparam int DataW = 64;

    typedef enum logic [2:0] {
        CMD_S2F = 3'd0,
        CMD_U2F = 3'd1,
        CMD_F2S = 3'd2,
        CMD_F2U = 3'd3,
        CMD_F2F = 3'd4
    } cmd_t;

    localparam logic [2:0] FMT_H = 3'd0;
    localparam logic [2:0] FMT_S = 3'd1;
    localparam logic [2:0] FMT_D = 3'd2;

    // Rounding request handed from the unpack stage to the leading zero count stage.
    typedef struct packed {
        logic        special;    // result already final
        logic [63:0] fixed_bits;
        logic        ok;
        logic        to_int;
        logic        is_signed;
        logic [2:0]  fmt;        // destination format (float) or int width code
        logic        neg;
        logic [63:0] mant;       // magnitude, not normalized
        logic signed [13:0] exp; // value = mant * 2^exp
    } req_t;

    // Request plus leading zero count, into the shift stage.
    typedef struct packed {
        logic        special;
        logic [63:0] fixed_bits;
        logic        ok;
        logic        to_int;
        logic        is_signed;
        logic [2:0]  fmt;
        logic        neg;
        logic [63:0] mant;
        logic signed [13:0] exp;
        logic [6:0]  lz;         // leading zero count of mant
    } norm_t;

    // Shifted value between the shift stage and the round stage.
    typedef struct packed {
        logic        special;
        logic [63:0] fixed_bits;
        logic        ok;
        logic        to_int;
        logic [2:0]  fmt;
        logic        neg;
        logic [64:0] kept;       // truncated mantissa (float) or magnitude (int)
        logic        rnd;        // round-up increment
        logic signed [13:0] target;
    } rnd_t;

    function automatic int unsigned mbits(input logic [2:0] f);
        unique case (f)
            FMT_H:   return 10;
            FMT_S:   return 23;
            default: return 52;
        endcase
    endfunction

    function automatic int unsigned ebits(input logic [2:0] f);
        unique case (f)
            FMT_H:   return 5;
            FMT_S:   return 8;
            default: return 11;
        endcase
    endfunction

    function automatic int unsigned fwidth(input logic [2:0] f);
        unique case (f)
            FMT_H:   return 16;
            FMT_S:   return 32;
            default: return 64;
        endcase
    endfunction

    function automatic int unsigned iwidth(input logic [2:0] c);
        unique case (c)
            3'd0:    return 1;
            3'd1:    return 8;
            3'd2:    return 16;
            3'd3:    return 32;
            default: return 64;
        endcase
    endfunction

    function automatic logic [63:0] lmask(input int unsigned w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic logic [63:0] inf_bits(input logic [2:0] f, input logic neg);
        logic [63:0] r;
        r = (lmask(ebits(f)) << mbits(f));
        if (neg)
            r = r | (64'd1 << (fwidth(f) - 1));
        return r;
    endfunction

endpackage

/* hdl/fifc_unpack.sv */
// ----------------------------------------------------------------------------
// fifc_unpack
// Stage 1: decode the command, unpack the source into sign, mantissa and
// exponent, and settle special cases (NaN, infinity, same width, invalid).
// ----------------------------------------------------------------------------
module fifc_unpack
    import fifc_pkg::*;
(
    input  logic [2:0]  cmd,
    input  logic [2:0]  source_width_code,
    input  logic [2:0]  dest_width_code,
    input  logic [63:0] operand_bits,
    output req_t        req
);

    always_comb
    begin
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] frac;
        logic [10:0] bexp;
        logic [10:0] emax;
        int unsigned w;
        int unsigned mb;
        int unsigned bias;
        int unsigned dmb;
        logic [63:0] pay;
        req = '0;
        req.fmt = dest_width_code;
        v = '0; x = '0; frac = '0; bexp = '0; emax = '0; w = 1; mb = 10;
        bias = 15; dmb = 10; pay = '0;
        if ((cmd == CMD_S2F || cmd == CMD_U2F) && source_width_code < 3'd5
            && dest_width_code < 3'd3)
        begin
            w = iwidth(source_width_code);
            v = operand_bits & lmask(w);
            req.ok = 1'b1;
            req.mant = v;
            if (cmd == CMD_S2F && v[w-1])
            begin
                req.neg = 1'b1;
                req.mant = (64'd0 - v) & lmask(w);
                if (req.mant == 64'd0)
                    req.mant = 64'd1 << (w - 1);
            end
        end
        else if (((cmd == CMD_F2S || cmd == CMD_F2U) && source_width_code < 3'd3
                  && dest_width_code < 3'd5)
                 || (cmd == CMD_F2F && source_width_code < 3'd3 && dest_width_code < 3'd3))
        begin
            mb = mbits(source_width_code);
            bias = (32'd1 << (ebits(source_width_code) - 1)) - 1;
            x = operand_bits & lmask(fwidth(source_width_code));
            req.neg = x[fwidth(source_width_code) - 1];
            bexp = 11'((x >> mb) & lmask(ebits(source_width_code)));
            emax = 11'(lmask(ebits(source_width_code)));
            frac = x & lmask(mb);
            req.to_int = (cmd != CMD_F2F);
            req.is_signed = (cmd == CMD_F2S);
            req.ok = 1'b1;
            if (bexp == 11'd0)
            begin
                req.mant = frac;
                req.exp = 14'(1 - $signed(bias) - $signed(mb));
            end
            else
            begin
                req.mant = frac | (64'd1 << mb);
                req.exp = 14'($signed({21'd0, bexp}) - $signed(bias) - $signed(mb));
            end
            if (cmd == CMD_F2F && source_width_code == dest_width_code)
            begin
                req.special = 1'b1;
                req.fixed_bits = x;
            end
            else if (bexp == emax)
            begin
                req.special = 1'b1;
                if (cmd != CMD_F2F)
                begin
                    req.ok = 1'b0;
                end
                else if (frac == 64'd0)
                begin
                    req.fixed_bits = inf_bits(dest_width_code, req.neg);
                end
                else
                begin
                    dmb = mbits(dest_width_code);
                    pay = (dmb >= mb) ? (frac << (dmb - mb)) : (frac >> (mb - dmb));
                    req.fixed_bits = inf_bits(dest_width_code, req.neg) | pay
                                   | (64'd1 << (dmb - 1));
                end
            end
        end
        else
        begin
            req.special = 1'b1;
        end
    end

endmodule

/* hdl/fifc_norm.sv */
// ----------------------------------------------------------------------------
// fifc_norm
// Stage 2: leading zero count of the mantissa.
// ----------------------------------------------------------------------------
module fifc_norm
    import fifc_pkg::*;
(
    input  req_t  req,
    output norm_t nrm
);

    logic [6:0] lz;

    // Priority encoder over 64 bits, tree built by synthesis.
    always_comb
    begin
        lz = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (req.mant[i])
                lz = 7'(63 - i);
        end
    end

    assign nrm = '{special: req.special, fixed_bits: req.fixed_bits, ok: req.ok,
                   to_int: req.to_int, is_signed: req.is_signed, fmt: req.fmt,
                   neg: req.neg, mant: req.mant, exp: req.exp, lz: lz};

endmodule

/* hdl/fifc_pack.sv */
// ----------------------------------------------------------------------------
// fifc_pack
// Stages 3 and 4: shift to the target position and range check, then
// round, normalize and assemble the float or integer result.
// ----------------------------------------------------------------------------
module fifc_pack
    import fifc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  norm_t       nrm,
    output logic [63:0] res,
    output logic        ok
);

    rnd_t rnd_next, rnd_reg;

    // Shift half
    always_comb
    begin
        int signed mb;
        int signed bias;
        int signed top;
        int signed target;
        int signed s;
        int signed e;
        int unsigned w;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        logic        big;
        mb = 10; bias = 15; top = 0; target = 0; s = 0; e = 0; w = 1;
        rem = '0; half = '0; mag = '0; big = 1'b0;
        rnd_next = '0;
        rnd_next.special    = nrm.special;
        rnd_next.fixed_bits = nrm.fixed_bits;
        rnd_next.ok         = nrm.ok;
        rnd_next.to_int     = nrm.to_int;
        rnd_next.fmt        = nrm.fmt;
        rnd_next.neg        = nrm.neg;
        e = int'(nrm.exp);
        if (!nrm.special && nrm.to_int)
        begin
            w = iwidth(nrm.fmt);
            if (nrm.mant != 64'd0)
            begin
                top = 63 - int'(nrm.lz);
                if (top + e > 63)
                    big = 1'b1;
                else if (e >= 0)
                    mag = nrm.mant << e;
                else if (-e < 64)
                    mag = nrm.mant >> (-e);
            end
            half = 64'd1 << (w - 1);
            if (big)
                rnd_next.ok = 1'b0;
            else if (nrm.is_signed)
                rnd_next.ok = nrm.neg ? (mag <= half) : (mag <= half - 64'd1);
            else
                rnd_next.ok = nrm.neg ? (mag == 64'd0) : (mag <= lmask(w));
            rnd_next.kept = {1'b0, mag};
        end
        else if (!nrm.special)
        begin
            mb = int'(mbits(nrm.fmt));
            bias = (1 << (ebits(nrm.fmt) - 1)) - 1;
            if (nrm.mant != 64'd0)
            begin
                top = 63 - int'(nrm.lz);
                target = top + e - mb;
                if (target < 1 - bias - mb)
                    target = 1 - bias - mb;
                s = target - e;
                if (s <= 0)
                    rnd_next.kept = {1'b0, nrm.mant << (-s)};
                else if (s == 64)
                    rnd_next.kept = (nrm.mant > (64'd1 << 63)) ? 65'd1 : 65'd0;
                else if (s < 64)
                begin
                    rem = nrm.mant & lmask(unsigned'(s));
                    half = 64'd1 << (s - 1);
                    rnd_next.kept = {1'b0, nrm.mant >> s};
                    rnd_next.rnd = (rem > half) || (rem == half && rnd_next.kept[0]);
                end
            end
            rnd_next.target = 14'(target);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) rnd_reg <= rnd_next;
    end

    // Round half
    always_comb
    begin
        int signed mb;
        int signed bias;
        int signed emaxv;
        int signed target;
        int signed bexp;
        int unsigned w;
        logic [64:0] kept;
        logic [63:0] sgn;
        mb = 10; bias = 15; emaxv = 31; target = 0; bexp = 0; w = 1;
        kept = '0; sgn = '0;
        res = '0;
        ok = rnd_reg.ok;
        if (rnd_reg.special)
        begin
            res = rnd_reg.fixed_bits;
        end
        else if (rnd_reg.to_int)
        begin
            w = iwidth(rnd_reg.fmt);
            res = (rnd_reg.neg ? (64'd0 - rnd_reg.kept[63:0]) : rnd_reg.kept[63:0])
                & lmask(w);
        end
        else
        begin
            mb = int'(mbits(rnd_reg.fmt));
            bias = (1 << (ebits(rnd_reg.fmt) - 1)) - 1;
            emaxv = (1 << ebits(rnd_reg.fmt)) - 1;
            sgn = rnd_reg.neg ? (64'd1 << (fwidth(rnd_reg.fmt) - 1)) : 64'd0;
            target = int'(rnd_reg.target);
            kept = rnd_reg.kept + {64'd0, rnd_reg.rnd};
            res = sgn;
            if (kept != 65'd0)
            begin
                if (kept == (65'd1 << (mb + 1)))
                begin
                    kept = kept >> 1;
                    target = target + 1;
                end
                if (kept >= (65'd1 << mb))
                begin
                    bexp = target + mb + bias;
                    if (bexp >= emaxv)
                        res = inf_bits(rnd_reg.fmt, rnd_reg.neg);
                    else
                        res = sgn | (64'(bexp) << mb)
                            | (kept[63:0] - (64'd1 << mb));
                end
                else
                begin
                    res = sgn | kept[63:0];
                end
            end
        end
        if (!ok)
            res = '0;
    end

endmodule

/* hdl/float_integer_format_converter.sv */
// ----------------------------------------------------------------------------
// float_integer_format_converter
// IEEE binary16/32/64 <-> integer conversion, four-stage pipeline.
//
//  channel | signals                                            | dir
//  in      | in_valid in_ready cmd source_width_code             | in
//          | dest_width_code operand_bits                       |
//  out     | out_valid out_ready result_bits valid_res          | out
//
// One item per cycle while the output does not stall; stages: unpack, leading zero
// count, shift, round. rst_n clears stage valid bits only. A stall on the output
// holds every stage whose successor is full; stages with a bubble still fill.
// ----------------------------------------------------------------------------
module float_integer_format_converter
    import fifc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [2:0]  source_width_code,
    input  logic [2:0]  dest_width_code,
    input  logic [63:0] operand_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_bits,
    output logic        valid_res
);

    req_t        s1_next, s1_reg;
    norm_t       s2_next, s2_reg;
    logic [63:0] res_next, res_reg;
    logic        ok_next, ok_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        en1, en2, en3, en4;

    fifc_unpack u_unpack (
        .cmd               (cmd),
        .source_width_code (source_width_code),
        .dest_width_code   (dest_width_code),
        .operand_bits      (operand_bits),
        .req               (s1_next)
    );

    fifc_norm u_norm (
        .req (s1_reg),
        .nrm (s2_next)
    );

    fifc_pack u_pack (
        .clk (clk),
        .en  (en3),
        .nrm (s2_reg),
        .res (res_next),
        .ok  (ok_next)
    );

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en4)
        begin
            res_reg <= res_next;
            ok_reg  <= ok_next;
        end
    end

    assign out_valid   = v4_reg;
    assign result_bits = res_reg;
    assign valid_res   = ok_reg;

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bits))
        else $error("output item changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |-> in_ready)
        else $error("input stalled with empty output stage");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready |=> v1_reg)
        else $error("accepted item lost in stage one");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> result_bits == 64'd0)
        else $error("invalid result not zero");

endmodule
